FILE: design/rau_pkg.sv
// Shared codes, command and status types for the rational arithmetic unit
`default_nettype none
package rau_pkg;

  localparam logic [2:0] KIND_REDUCE = 3'd0;
  localparam logic [2:0] KIND_NEGATE = 3'd1;
  localparam logic [2:0] KIND_ADD    = 3'd2;
  localparam logic [2:0] KIND_SUB    = 3'd3;
  localparam logic [2:0] KIND_MUL    = 3'd4;
  localparam logic [2:0] KIND_DIV    = 3'd5;
  localparam logic [2:0] KIND_EQ     = 3'd6;
  localparam logic [2:0] KIND_LT     = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DIV = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_BAD_DEN  = 2'd3;

  localparam logic [63:0] MAX_DEN     = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] MAX_NEG_MAG = 64'h0000_0000_8000_0000;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic comb;
    logic gcd_step;
    logic load_div;
    logic div_step;
    logic load_out;
  } rau_cmd_t;

  typedef struct packed {
    logic early_end;
    logic gcd_done;
    logic div_last;
    logic out_free;
  } rau_stat_t;

endpackage
`default_nettype wire

FILE: design/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit
// One request at a time. Errors and compares go from the multiply state straight to the result
// load; a fraction result also passes through the combine state, the binary GCD loop and two
// restoring dividers that divide numerator and denominator by the GCD. The GCD loop and the
// dividers set how long a fraction result takes. A finished result waits in the output register.
`default_nettype none
module rational_arithmetic_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,  // a_num[31:0], a_den[62:32], b_num[94:63], b_den[125:95]
  input  wire logic [2:0]   s_tuser,  // kind
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [71:0]       m_tdata   // res_num[31:0], res_den[62:32], truth[63], status[65:64]
);
  import rau_pkg::*;

  rau_cmd_t  cmd;
  rau_stat_t stat;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rau_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_kind   (s_tuser),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
`default_nettype wire

FILE: design/rau_dp.sv
// Datapath: operand registers, products, binary GCD, dividers and result register
`default_nettype none
module rau_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rau_pkg::rau_cmd_t cmd,
  output rau_pkg::rau_stat_t    stat,
  input  wire logic [2:0]       in_kind,
  input  wire logic [127:0]     in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [71:0]           out_data
);
  import rau_pkg::*;

  logic [2:0]         kind;
  logic signed [31:0] an, bn;
  logic [30:0]        ad, bd;
  logic signed [63:0] pa, pb, pd;
  logic [63:0]        nmag, dmag;
  logic               neg;
  logic [63:0]        x, y;
  logic [5:0]         k;
  logic [63:0]        gr, dq1, dq2, rm1, rm2;
  logic [5:0]         cnt;

  logic               err_den, err_div, is_cmp;
  logic signed [31:0] opa, opd, ad_s, bd_s;
  logic signed [63:0] n_c, d_c;
  logic [63:0]        gsel;
  logic [64:0]        t1, t2, s1, s2;
  logic               ge1, ge2, ovf, truth;
  logic [31:0]        rn;
  logic [1:0]         st;
  logic [31:0]        o_num;
  logic [30:0]        o_den;

  assign ad_s    = $signed({1'b0, ad});
  assign bd_s    = $signed({1'b0, bd});
  assign err_den = (ad == 31'd0) ||
                   ((kind != KIND_REDUCE) && (kind != KIND_NEGATE) && (bd == 31'd0));
  assign err_div = (kind == KIND_DIV) && (bn == 32'sd0);
  assign is_cmp  = (kind == KIND_EQ) || (kind == KIND_LT);
  assign opa     = (kind == KIND_MUL) ? bn : bd_s;
  assign opd     = (kind == KIND_DIV) ? bn : bd_s;

  always_comb begin
    n_c = 64'sd0;
    d_c = 64'sd1;
    case (kind)
      KIND_REDUCE: begin n_c = 64'(an);  d_c = 64'(ad_s); end
      KIND_NEGATE: begin n_c = -64'(an); d_c = 64'(ad_s); end
      KIND_ADD:    begin n_c = pa + pb;  d_c = pd; end
      KIND_SUB:    begin n_c = pa - pb;  d_c = pd; end
      KIND_MUL:    begin n_c = pa;       d_c = pd; end
      KIND_DIV: begin
        if (pd < 0) begin
          n_c = -pa;
          d_c = -pd;
        end else begin
          n_c = pa;
          d_c = pd;
        end
      end
      default: begin n_c = 64'sd0; d_c = 64'sd1; end
    endcase
  end

  assign gsel = ((x == 64'd0) ? y : x) << k;
  assign t1   = {rm1, dq1[63]};
  assign t2   = {rm2, dq2[63]};
  assign s1   = t1 - {1'b0, gr};
  assign s2   = t2 - {1'b0, gr};
  assign ge1  = t1 >= {1'b0, gr};
  assign ge2  = t2 >= {1'b0, gr};

  assign ovf   = (dq2 > MAX_DEN) || (neg ? (dq1 > MAX_NEG_MAG) : (dq1 > MAX_DEN));
  assign rn    = neg ? (32'd0 - dq1[31:0]) : dq1[31:0];
  assign truth = (kind == KIND_EQ) ? (pa == pb) : (pa < pb);

  always_comb begin
    st    = ST_OK;
    o_num = 32'd0;
    o_den = 31'd1;
    if (err_den) begin
      st = ST_BAD_DEN;
    end else if (err_div) begin
      st = ST_ZERO_DIV;
    end else if (is_cmp) begin
      st = ST_OK;
    end else if (ovf) begin
      st = ST_OVERFLOW;
    end else begin
      o_num = rn;
      o_den = dq2[30:0];
    end
  end

  assign stat.early_end = err_den || err_div || is_cmp;
  assign stat.gcd_done  = (x == 64'd0) || (y == 64'd0);
  assign stat.div_last  = (cnt == 6'd63);
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind <= in_kind;
      an   <= $signed(in_data[31:0]);
      ad   <= in_data[62:32];
      bn   <= $signed(in_data[94:63]);
      bd   <= in_data[125:95];
    end
    if (cmd.mul) begin
      pa <= an * opa;
      pb <= bn * ad_s;
      pd <= ad_s * opd;
    end
    if (cmd.comb) begin
      neg  <= n_c < 0;
      nmag <= (n_c < 0) ? 64'(-n_c) : 64'(n_c);
      dmag <= 64'(d_c);
      x    <= (n_c < 0) ? 64'(-n_c) : 64'(n_c);
      y    <= 64'(d_c);
      k    <= 6'd0;
    end
    if (cmd.gcd_step) begin
      if (!x[0] && !y[0]) begin
        x <= x >> 1;
        y <= y >> 1;
        k <= k + 6'd1;
      end else if (!x[0]) begin
        x <= x >> 1;
      end else if (!y[0]) begin
        y <= y >> 1;
      end else if (x >= y) begin
        x <= x - y;
      end else begin
        y <= y - x;
      end
    end
    if (cmd.load_div) begin
      gr  <= gsel;
      dq1 <= nmag;
      dq2 <= dmag;
      rm1 <= 64'd0;
      rm2 <= 64'd0;
      cnt <= 6'd0;
    end
    if (cmd.div_step) begin
      rm1 <= ge1 ? s1[63:0] : t1[63:0];
      rm2 <= ge2 ? s2[63:0] : t2[63:0];
      dq1 <= {dq1[62:0], ge1};
      dq2 <= {dq2[62:0], ge2};
      cnt <= cnt + 6'd1;
    end
    if (cmd.load_out) begin
      out_data <= {6'd0, st, (is_cmp && !err_den) ? truth : 1'b0, o_den, o_num};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: design/rau_ctrl.sv
// Controller: sequences multiply, GCD, divide and result load for one request
`default_nettype none
module rau_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rau_pkg::rau_stat_t stat,
  output rau_pkg::rau_cmd_t      cmd
);
  import rau_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_COMB, S_GCD, S_DIV, S_FIN} state_t;
  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = stat.early_end ? S_FIN : S_COMB;
      end
      S_COMB: begin
        cmd.comb   = 1'b1;
        state_next = S_GCD;
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          cmd.load_div = 1'b1;
          state_next   = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/rau_chk.sv
// Port checker for the rational arithmetic unit and its bind
`default_nettype none
module rau_chk (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [71:0]  m_tdata
);
  import rau_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_err_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[65:64] != ST_OK) |->
      (m_tdata[31:0] == 32'd0) && (m_tdata[62:32] == 31'd1) && !m_tdata[63])
    else $error("error result not cleared");

  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[62:32] != 31'd0))
    else $error("zero result denominator");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

endmodule

bind rational_arithmetic_unit rau_chk u_rau_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
